### rtl/assert_macros.svh
// Assertion helpers for the RTL files; the saddle point finder unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GSPF_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GSPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/gspf_pkg.sv
package gspf_pkg;

   localparam int COLUMN_BITS    = 8;
   localparam int ROW_BITS       = 12;
   localparam int COLS_CFG_BITS  = 9;
   localparam int ROWS_CFG_BITS  = 13;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 13;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_COLUMNS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_ROWS    = 2'd1;

   localparam logic [COLS_CFG_BITS-1:0] COLS_RESET = 9'd256;
   localparam logic [COLS_CFG_BITS-1:0] COLS_MIN   = 9'd3;
   localparam logic [ROWS_CFG_BITS-1:0] ROWS_RESET = 13'd256;
   localparam logic [ROWS_CFG_BITS-1:0] ROWS_MIN   = 13'd3;
   localparam logic [ROWS_CFG_BITS-1:0] ROWS_MAX   = 13'd4096;

   // Grid position and frame flags carried along with a sample
   typedef struct packed {
      logic                   last;
      logic                   eval;
      logic [COLUMN_BITS-1:0] column;
      logic [ROW_BITS-1:0]    row;
   } tag_type;

   // Saddle test outcome known before the products are formed
   typedef struct packed {
      logic shape;
      logic use_cmp;
      logic fixed_neg;
   } hess_type;

endpackage

### rtl/gspf_ifs.sv
interface gspf_req_if #(
   parameter int SAMPLE_BITS = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] psi_sample;

   modport source (output valid, output psi_sample, input ready);
   modport sink (input valid, input psi_sample, output ready);
endinterface

interface gspf_rsp_if import gspf_pkg::*; #(
   parameter int SAMPLE_BITS = 32
);
   logic                          valid;
   logic                          ready;
   logic                          saddle_found;
   logic [COLUMN_BITS-1:0]        saddle_column;
   logic [ROW_BITS-1:0]           saddle_row;
   logic signed [SAMPLE_BITS-1:0] saddle_psi;

   modport source (output valid, output saddle_found, output saddle_column,
                   output saddle_row, output saddle_psi, input ready);
   modport sink (input valid, input saddle_found, input saddle_column,
                 input saddle_row, input saddle_psi, output ready);
endinterface

interface gspf_csr_if import gspf_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/gspf_hessian_mult.sv
module gspf_hessian_mult #(
   parameter int MAG_BITS = 34
) (
   input  logic                    clock,
   input  logic                    enable,
   input  logic [MAG_BITS-1:0]     rr_mag,
   input  logic [MAG_BITS-1:0]     zz_mag,
   input  logic [MAG_BITS-1:0]     rz_mag,
   output logic [2*MAG_BITS-1:0]   curv_prod,
   output logic [2*MAG_BITS-1:0]   twist_prod
);

   localparam int LO_BITS   = (MAG_BITS + 1) / 2;
   localparam int HI_BITS   = MAG_BITS - LO_BITS;
   localparam int LL_BITS   = 2 * LO_BITS;
   localparam int LH_BITS   = LO_BITS + HI_BITS;
   localparam int HH_BITS   = 2 * HI_BITS;
   localparam int PROD_BITS = 2 * MAG_BITS;

   logic [LO_BITS-1:0] rr_lo, zz_lo, rz_lo;
   logic [HI_BITS-1:0] rr_hi, zz_hi, rz_hi;

   logic [LL_BITS-1:0]   ab_ll_ff, cc_ll_ff;
   logic [LH_BITS-1:0]   ab_lh_ff, ab_hl_ff, cc_lh_ff;
   logic [HH_BITS-1:0]   ab_hh_ff, cc_hh_ff;
   logic [PROD_BITS-1:0] curv_ff, twist_ff;

   assign rr_lo = rr_mag[LO_BITS-1:0];
   assign zz_lo = zz_mag[LO_BITS-1:0];
   assign rz_lo = rz_mag[LO_BITS-1:0];
   assign rr_hi = rr_mag[MAG_BITS-1:LO_BITS];
   assign zz_hi = zz_mag[MAG_BITS-1:LO_BITS];
   assign rz_hi = rz_mag[MAG_BITS-1:LO_BITS];

   // Partial products of |frr|*|fzz| and |frz|^2
   always_ff @(posedge clock) begin
      if (enable) begin
         ab_ll_ff <= LL_BITS'(rr_lo) * LL_BITS'(zz_lo);
         ab_lh_ff <= LH_BITS'(rr_lo) * LH_BITS'(zz_hi);
         ab_hl_ff <= LH_BITS'(rr_hi) * LH_BITS'(zz_lo);
         ab_hh_ff <= HH_BITS'(rr_hi) * HH_BITS'(zz_hi);
         cc_ll_ff <= LL_BITS'(rz_lo) * LL_BITS'(rz_lo);
         cc_lh_ff <= LH_BITS'(rz_lo) * LH_BITS'(rz_hi);
         cc_hh_ff <= HH_BITS'(rz_hi) * HH_BITS'(rz_hi);
      end
   end

   // Recombine; the cross term of the square counts twice
   always_ff @(posedge clock) begin
      if (enable) begin
         curv_ff <= (PROD_BITS'(ab_hh_ff) << LL_BITS)
                  + ((PROD_BITS'(ab_lh_ff) + PROD_BITS'(ab_hl_ff)) << LO_BITS)
                  + PROD_BITS'(ab_ll_ff);
         twist_ff <= (PROD_BITS'(cc_hh_ff) << LL_BITS)
                   + (PROD_BITS'(cc_lh_ff) << (LO_BITS + 1))
                   + PROD_BITS'(cc_ll_ff);
      end
   end

   assign curv_prod  = curv_ff;
   assign twist_prod = twist_ff;

endmodule

### rtl/grid_saddle_point_finder_unit.sv
// Saddle point search over a streamed 2-D grid of signed Q16.16 flux samples.
// req_chan carries one grid sample per request, in row-major order; a sample
// is taken at a clock edge where valid and ready are both high. csr_chan
// writes grid_columns (index 0) and grid_rows (index 1); it is always ready
// and must only be written while no frame is in flight. rsp_chan carries one
// result per frame: found flag, column, row and value of the first saddle
// with the highest value, all zero when none was found.
// Throughput: one sample per cycle. Each sample runs through a six-register
// pipeline: line-buffer read, 3x3 window, differences, partial products,
// product sums, then the best-saddle update. The result of a frame is loaded
// into the rsp_chan output register as its last sample leaves the product sums.
// The result sits in an output register; while it waits, samples of the next
// frame keep flowing. Only when that next frame's result reaches the last
// stage with the previous one still untaken does the pipeline stall and
// ready drop, until the receiver takes it.
// Reset (synchronous) empties the pipeline, clears the counters and the held
// saddle and sets both grid sizes to 256. The line buffers are not cleared.
`include "assert_macros.svh"

module grid_saddle_point_finder_unit import gspf_pkg::*; #(
   parameter int MAX_COLUMNS = 256,
   parameter int SAMPLE_BITS = 32
) (
   input logic        clock,
   input logic        reset,
   gspf_req_if.sink   req_chan,
   gspf_rsp_if.source rsp_chan,
   gspf_csr_if.sink   csr_chan
);

   localparam int ADDR_BITS = $clog2(MAX_COLUMNS);
   localparam int DIFF_BITS = SAMPLE_BITS + 2;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int CMP_BITS  = PROD_BITS + 4;

   // ---------------- configuration ----------------
   logic [COLS_CFG_BITS-1:0] grid_columns_ff, cols_lim;
   logic [ROWS_CFG_BITS-1:0] grid_rows_ff, rows_lim;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_columns_ff <= COLS_RESET;
         grid_rows_ff    <= ROWS_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_GRID_COLUMNS: grid_columns_ff <= csr_chan.data[COLS_CFG_BITS-1:0];
            CSR_GRID_ROWS:    grid_rows_ff    <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (grid_columns_ff < COLS_MIN) begin
         cols_lim = COLS_MIN;
      end else if (int'(grid_columns_ff) > MAX_COLUMNS) begin
         cols_lim = COLS_CFG_BITS'(MAX_COLUMNS);
      end else begin
         cols_lim = grid_columns_ff;
      end
      if (grid_rows_ff < ROWS_MIN) begin
         rows_lim = ROWS_MIN;
      end else if (grid_rows_ff > ROWS_MAX) begin
         rows_lim = ROWS_MAX;
      end else begin
         rows_lim = grid_rows_ff;
      end
   end

   // ---------------- flow control ----------------
   logic    adv, accept, fire, emit, take_fire;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    e_valid_ff;
   tag_type e_tag_ff;

   // Stall only when a second result would land on an untaken one
   assign adv      = !(e_valid_ff && e_tag_ff.last && rsp_valid_ff);
   assign accept   = req_chan.valid && adv;
   assign req_chan.ready = adv;

   // ---------------- position counters ----------------
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0]    row_ff, row_in;
   logic                   col_end, row_end;
   tag_type                tag_in;

   assign col_end = ({1'b0, col_ff} + 9'd1) >= cols_lim;
   assign row_end = ({1'b0, row_ff} + 13'd1) >= rows_lim;

   always_comb begin
      col_in = col_ff + 8'd1;
      row_in = row_ff;
      if (col_end) begin
         col_in = '0;
         row_in = row_end ? '0 : row_ff + 12'd1;
      end
      tag_in.last   = col_end && row_end;
      tag_in.eval   = (row_ff >= 12'd2) && (col_ff >= 8'd2);
      tag_in.column = col_ff - 8'd1;
      tag_in.row    = row_ff - 12'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------- line buffers, stage A ----------------
   logic [SAMPLE_BITS-1:0]        upper_mem [MAX_COLUMNS];
   logic [SAMPLE_BITS-1:0]        middle_mem [MAX_COLUMNS];
   logic [ADDR_BITS-1:0]          rd_addr, a_addr_ff;
   logic [SAMPLE_BITS-1:0]        up_rd_ff, mid_rd_ff;
   logic signed [SAMPLE_BITS-1:0] a_x_ff;
   logic                          a_valid_ff;
   tag_type                       a_tag_ff;

   assign rd_addr = ADDR_BITS'(col_ff);

   // Middle row is replaced at once; the upper row takes the old middle
   // value once the read data is back and the pipeline advances.
   always_ff @(posedge clock) begin
      if (accept) begin
         up_rd_ff            <= upper_mem[rd_addr];
         mid_rd_ff           <= middle_mem[rd_addr];
         middle_mem[rd_addr] <= req_chan.psi_sample;
      end
      if (a_valid_ff && adv) begin
         upper_mem[a_addr_ff] <= mid_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_x_ff    <= req_chan.psi_sample;
         a_addr_ff <= rd_addr;
         a_tag_ff  <= tag_in;
      end
   end

   // ---------------- 3x3 window, stage B ----------------
   logic signed [SAMPLE_BITS-1:0] window_ff [9];
   logic                          b_valid_ff;
   tag_type                       b_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff && adv) begin
         window_ff[0] <= window_ff[1];
         window_ff[1] <= window_ff[2];
         window_ff[2] <= $signed(up_rd_ff);
         window_ff[3] <= window_ff[4];
         window_ff[4] <= window_ff[5];
         window_ff[5] <= $signed(mid_rd_ff);
         window_ff[6] <= window_ff[7];
         window_ff[7] <= window_ff[8];
         window_ff[8] <= a_x_ff;
         b_tag_ff     <= a_tag_ff;
      end
   end

   // ---------------- differences and pair test, stage C ----------------
   logic signed [DIFF_BITS-1:0]   frr, fzz, frz;
   logic [DIFF_BITS-1:0]          rr_mag, zz_mag, rz_mag;
   logic signed [SAMPLE_BITS-1:0] pair_hi [4];
   logic signed [SAMPLE_BITS-1:0] pair_lo [4];
   logic                          above, below;
   hess_type                      hess_in;

   logic                          c_valid_ff;
   tag_type                       c_tag_ff;
   hess_type                      c_hess_ff;
   logic signed [SAMPLE_BITS-1:0] c_h_ff;
   logic [DIFF_BITS-1:0]          c_rr_ff, c_zz_ff, c_rz_ff;

   always_comb begin
      frr = DIFF_BITS'(window_ff[5]) + DIFF_BITS'(window_ff[3])
          - (DIFF_BITS'(window_ff[4]) <<< 1);
      fzz = DIFF_BITS'(window_ff[7]) + DIFF_BITS'(window_ff[1])
          - (DIFF_BITS'(window_ff[4]) <<< 1);
      frz = DIFF_BITS'(window_ff[8]) + DIFF_BITS'(window_ff[0])
          - DIFF_BITS'(window_ff[2]) - DIFF_BITS'(window_ff[6]);
      rr_mag = frr[DIFF_BITS-1] ? $unsigned(-frr) : $unsigned(frr);
      zz_mag = fzz[DIFF_BITS-1] ? $unsigned(-fzz) : $unsigned(fzz);
      rz_mag = frz[DIFF_BITS-1] ? $unsigned(-frz) : $unsigned(frz);

      // Opposite neighbor pairs: anti-diagonal, row, diagonal, column
      pair_hi[0] = window_ff[2];  pair_lo[0] = window_ff[6];
      pair_hi[1] = window_ff[5];  pair_lo[1] = window_ff[3];
      pair_hi[2] = window_ff[8];  pair_lo[2] = window_ff[0];
      pair_hi[3] = window_ff[7];  pair_lo[3] = window_ff[1];
      above = 1'b0;
      below = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (pair_hi[i] > window_ff[4] && pair_lo[i] > window_ff[4]) begin
            above = 1'b1;
         end
         if (pair_hi[i] < window_ff[4] && pair_lo[i] < window_ff[4]) begin
            below = 1'b1;
         end
      end

      hess_in.shape = b_tag_ff.eval && above && below;
      if (frr == '0 || fzz == '0) begin
         hess_in.use_cmp   = 1'b0;
         hess_in.fixed_neg = (frz != '0);
      end else if (frr[DIFF_BITS-1] != fzz[DIFF_BITS-1]) begin
         hess_in.use_cmp   = 1'b0;
         hess_in.fixed_neg = 1'b1;
      end else begin
         hess_in.use_cmp   = 1'b1;
         hess_in.fixed_neg = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_valid_ff && adv) begin
         c_tag_ff  <= b_tag_ff;
         c_hess_ff <= hess_in;
         c_h_ff    <= window_ff[4];
         c_rr_ff   <= rr_mag;
         c_zz_ff   <= zz_mag;
         c_rz_ff   <= rz_mag;
      end
   end

   // ---------------- products, stages D and E ----------------
   logic [PROD_BITS-1:0]          curv_prod, twist_prod;
   logic                          d_valid_ff;
   tag_type                       d_tag_ff;
   hess_type                      d_hess_ff, e_hess_ff;
   logic signed [SAMPLE_BITS-1:0] d_h_ff, e_h_ff;

   gspf_hessian_mult #(
      .MAG_BITS (DIFF_BITS)
   ) u_hessian_mult (
      .clock      (clock),
      .enable     (adv),
      .rr_mag     (c_rr_ff),
      .zz_mag     (c_zz_ff),
      .rz_mag     (c_rz_ff),
      .curv_prod  (curv_prod),
      .twist_prod (twist_prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_valid_ff && adv) begin
         d_tag_ff  <= c_tag_ff;
         d_hess_ff <= c_hess_ff;
         d_h_ff    <= c_h_ff;
      end
      if (d_valid_ff && adv) begin
         e_tag_ff  <= d_tag_ff;
         e_hess_ff <= d_hess_ff;
         e_h_ff    <= d_h_ff;
      end
   end

   // ---------------- best saddle and result ----------------
   logic                          best_valid_ff, best_valid_in;
   logic [COLUMN_BITS-1:0]        best_column_ff, best_column_in;
   logic [ROW_BITS-1:0]           best_row_ff, best_row_in;
   logic signed [SAMPLE_BITS-1:0] best_value_ff, best_value_in;
   logic                          hess_neg, take;
   logic                          found_now;
   logic [COLUMN_BITS-1:0]        column_now;
   logic [ROW_BITS-1:0]           row_now;
   logic signed [SAMPLE_BITS-1:0] value_now;

   logic                          rsp_found_ff;
   logic [COLUMN_BITS-1:0]        rsp_column_ff;
   logic [ROW_BITS-1:0]           rsp_row_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_psi_ff;

   assign hess_neg  = e_hess_ff.use_cmp ? ({curv_prod, 4'b0000} < CMP_BITS'(twist_prod))
                                        : e_hess_ff.fixed_neg;
   assign take      = e_hess_ff.shape && hess_neg
                   && (!best_valid_ff || e_h_ff > best_value_ff);
   assign fire      = e_valid_ff && adv;
   assign take_fire = fire && take;
   assign emit      = fire && e_tag_ff.last;

   assign found_now  = best_valid_ff || take;
   assign column_now = take ? e_tag_ff.column : best_column_ff;
   assign row_now    = take ? e_tag_ff.row : best_row_ff;
   assign value_now  = take ? e_h_ff : best_value_ff;

   always_comb begin
      best_valid_in  = best_valid_ff;
      best_column_in = best_column_ff;
      best_row_in    = best_row_ff;
      best_value_in  = best_value_ff;
      if (take_fire) begin
         best_valid_in  = 1'b1;
         best_column_in = e_tag_ff.column;
         best_row_in    = e_tag_ff.row;
         best_value_in  = e_h_ff;
      end
      // Frame done: drop the held saddle
      if (emit) begin
         best_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff <= 1'b0;
      end else begin
         best_valid_ff <= best_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_column_ff <= best_column_in;
      best_row_ff    <= best_row_in;
      best_value_ff  <= best_value_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_found_ff  <= found_now;
         rsp_column_ff <= found_now ? column_now : '0;
         rsp_row_ff    <= found_now ? row_now : '0;
         rsp_psi_ff    <= found_now ? value_now : '0;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.saddle_found  = rsp_found_ff;
   assign rsp_chan.saddle_column = rsp_column_ff;
   assign rsp_chan.saddle_row    = rsp_row_ff;
   assign rsp_chan.saddle_psi    = rsp_psi_ff;

   // ---------------- checks ----------------
   `GSPF_ASSERT_IMPLIES(a_no_result_overwrite, clock, reset,
      rsp_valid_ff && !rsp_chan.ready, !emit, "result overwritten while stalled")
   `GSPF_ASSERT_IMPLIES(a_result_from_frame_end, clock, reset,
      $rose(rsp_valid_ff), $past(emit), "result without a frame end")
   `GSPF_ASSERT_IMPLIES(a_column_in_range, clock, reset,
      1'b1, int'(col_ff) < MAX_COLUMNS, "column counter beyond line buffer")
   `GSPF_ASSERT_IMPLIES(a_line_buffer_no_clash, clock, reset,
      accept && a_valid_ff, rd_addr != a_addr_ff, "line buffer read hits pending write")

endmodule

### tb/sv/saddle_checker.sv
module saddle_checker import gspf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic signed [31:0]        req_psi,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic                      rsp_found,
   input  logic [COLUMN_BITS-1:0]    rsp_column,
   input  logic [ROW_BITS-1:0]       rsp_row,
   input  logic signed [31:0]        rsp_psi,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output int                        mismatches,
   output int                        outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_DEPTH = 256;
   localparam int ROWS_LIMIT = 4096;
   localparam int PAIR_FIRST[4]  = '{2, 5, 8, 7};
   localparam int PAIR_SECOND[4] = '{6, 3, 0, 1};

   typedef logic signed [31:0] sample_type;

   typedef struct {
      logic                   found;
      logic [COLUMN_BITS-1:0] column;
      logic [ROW_BITS-1:0]    row;
      sample_type             psi;
   } frame_result_type;

   frame_result_type         frame_results[$];
   sample_type               upper_line[LINE_DEPTH];
   sample_type               middle_line[LINE_DEPTH];
   sample_type               window[9];
   logic [COLS_CFG_BITS-1:0] columns_cfg;
   logic [ROWS_CFG_BITS-1:0] rows_cfg;
   int unsigned              column_pos;
   int unsigned              row_pos;
   logic                     best_held;
   logic [COLUMN_BITS-1:0]   best_column;
   logic [ROW_BITS-1:0]      best_row;
   sample_type               best_psi;

   task automatic report_fault(input string what);
      $display("%0t ns saddle check: %s", $time, what);
      mismatches++;
   endtask

   // Exact sign test of 16*frr*fzz - frz^2, then the opposite neighbor pairs.
   function automatic bit window_is_saddle();
      logic signed [127:0] v[9];
      logic signed [127:0] frr, fzz, frz, det;
      bit above, below;
      foreach (v[i]) v[i] = window[i];
      frr = v[5] - 2 * v[4] + v[3];
      fzz = v[7] - 2 * v[4] + v[1];
      frz = v[8] + v[0] - v[2] - v[6];
      det = 16 * frr * fzz - frz * frz;
      if (det >= 0) return 1'b0;
      above = 1'b0;
      below = 1'b0;
      for (int p = 0; p < 4; p++) begin
         if (v[PAIR_FIRST[p]] > v[4] && v[PAIR_SECOND[p]] > v[4]) begin
            above = 1'b1;
         end else if (v[PAIR_FIRST[p]] < v[4] && v[PAIR_SECOND[p]] < v[4]) begin
            below = 1'b1;
         end
      end
      return above && below;
   endfunction

   task automatic take_sample(input sample_type x);
      int unsigned      cols, rows, slot;
      sample_type       up_val, mid_val;
      frame_result_type done;
      cols = columns_cfg;
      if (cols < 3) cols = 3;
      if (cols > LINE_DEPTH) cols = LINE_DEPTH;
      rows = rows_cfg;
      if (rows < 3) rows = 3;
      if (rows > ROWS_LIMIT) rows = ROWS_LIMIT;

      slot = column_pos % LINE_DEPTH;
      up_val = upper_line[slot];
      mid_val = middle_line[slot];
      upper_line[slot] = mid_val;
      middle_line[slot] = x;

      window[0] = window[1];
      window[1] = window[2];
      window[3] = window[4];
      window[4] = window[5];
      window[6] = window[7];
      window[7] = window[8];
      window[2] = up_val;
      window[5] = mid_val;
      window[8] = x;

      // Only a strictly higher center may replace the held saddle.
      if (row_pos >= 2 && column_pos >= 2 && (!best_held || window[4] > best_psi)
          && window_is_saddle()) begin
         best_held = 1'b1;
         best_column = COLUMN_BITS'(column_pos - 1);
         best_row = ROW_BITS'(row_pos - 1);
         best_psi = window[4];
      end

      if (column_pos + 1 >= cols) begin
         column_pos = 0;
         if (row_pos + 1 >= rows) begin
            done.found = best_held;
            done.column = best_column;
            done.row = best_row;
            done.psi = best_psi;
            frame_results.push_back(done);
            row_pos = 0;
            best_held = 1'b0;
            best_column = '0;
            best_row = '0;
            best_psi = '0;
         end else begin
            row_pos = (row_pos + 1) & 32'hFFF;
         end
      end else begin
         column_pos = (column_pos + 1) & 32'hFF;
      end
   endtask

   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         foreach (upper_line[i]) upper_line[i] = '0;
         foreach (middle_line[i]) middle_line[i] = '0;
         foreach (window[i]) window[i] = '0;
         columns_cfg = COLS_RESET;
         rows_cfg = ROWS_RESET;
         column_pos = 0;
         row_pos = 0;
         best_held = 1'b0;
         best_column = '0;
         best_row = '0;
         best_psi = '0;
         frame_results.delete();
         mismatches = 0;
         outstanding = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frame_results.size() == 0) begin
               report_fault($sformatf("result with no frame pending: found %0b col %0d row %0d psi %0d",
                                      rsp_found, rsp_column, rsp_row, rsp_psi));
            end else begin
               want = frame_results.pop_front();
               if (rsp_found !== want.found)
                  report_fault($sformatf("found got %b want %b", rsp_found, want.found));
               if (rsp_column !== want.column)
                  report_fault($sformatf("column got %0d want %0d", rsp_column, want.column));
               if (rsp_row !== want.row)
                  report_fault($sformatf("row got %0d want %0d", rsp_row, want.row));
               if (rsp_psi !== want.psi)
                  report_fault($sformatf("psi got %0d want %0d", rsp_psi, want.psi));
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_GRID_COLUMNS) begin
               columns_cfg = csr_data[COLS_CFG_BITS-1:0];
            end else if (csr_index == CSR_GRID_ROWS) begin
               rows_cfg = csr_data[ROWS_CFG_BITS-1:0];
            end
         end
         if (req_valid && req_ready) take_sample(req_psi);
         outstanding = frame_results.size();
      end
   end

endmodule

### tb/sv/testbench.sv
module testbench import gspf_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HIGH = 2'd3;
   localparam int RANDOM_ITEMS = 1350;
   localparam int MAX_GAP      = 14;
   localparam logic signed [31:0] PSI_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] PSI_MIN = 32'sh8000_0000;

   typedef enum {
      SHAPE_QUADRATIC,
      SHAPE_TILED,
      SHAPE_NARROW,
      SHAPE_NOISE,
      SHAPE_EXTREME,
      SHAPE_PLATEAU
   } frame_shape_type;

   logic clock = 1'b0;
   logic reset;

   always #10ns clock = ~clock;

   gspf_req_if #(.SAMPLE_BITS(32)) req_if();
   gspf_rsp_if #(.SAMPLE_BITS(32)) rsp_if();
   gspf_csr_if csr_if();

   grid_saddle_point_finder_unit #(
      .MAX_COLUMNS(256),
      .SAMPLE_BITS(32)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_chan(csr_if)
   );

   int mismatches;
   int outstanding;

   saddle_checker watcher (
      .clock(clock),
      .reset(reset),
      .req_valid(req_if.valid),
      .req_ready(req_if.ready),
      .req_psi(req_if.psi_sample),
      .rsp_valid(rsp_if.valid),
      .rsp_ready(rsp_if.ready),
      .rsp_found(rsp_if.saddle_found),
      .rsp_column(rsp_if.saddle_column),
      .rsp_row(rsp_if.saddle_row),
      .rsp_psi(rsp_if.saddle_psi),
      .csr_valid(csr_if.valid),
      .csr_ready(csr_if.ready),
      .csr_index(csr_if.index),
      .csr_data(csr_if.data),
      .mismatches(mismatches),
      .outstanding(outstanding)
   );

   bit     req_calm;
   bit     rsp_calm;
   int     columns_now;
   int     rows_now;
   int     random_items;
   longint center_col, center_row, bend_col, bend_row, twist, offset, step_size;
   int unsigned jitter;

   function automatic int next_gap(input bit calm);
      return calm ? 0 : $urandom_range(MAX_GAP, 0);
   endfunction

   function automatic int clamp_size(input int raw, input int low, input int high);
      return (raw < low) ? low : (raw > high) ? high : raw;
   endfunction

   task automatic push_sample(input logic signed [31:0] value);
      int gap;
      gap = next_gap(req_calm);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.psi_sample <= value;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data <= data;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      @(negedge clock);
      csr_if.valid <= 1'b0;
      @(negedge clock);
      case (index)
         CSR_GRID_COLUMNS: columns_now = clamp_size(int'(data[COLS_CFG_BITS-1:0]), 3, 256);
         CSR_GRID_ROWS:    rows_now = clamp_size(int'(data), 3, 4096);
         default: ;
      endcase
   endtask

   // Drop valid, wait out every pending frame, then let the pipeline empty.
   task automatic finish_outstanding();
      req_if.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic logic signed [31:0] grid_value(input frame_shape_type shape,
                                                     input int col, input int row);
      longint dc, dr, acc;
      dc = col - center_col;
      dr = row - center_row;
      acc = offset;
      case (shape)
         SHAPE_QUADRATIC:
            acc = offset + bend_col * dc * dc - bend_row * dr * dr + twist * dc * dr
                  + longint'($urandom_range(jitter, 0));
         // Saddles wherever column and row are both odd or both even, all of equal value
         SHAPE_TILED:
            acc = offset + ((col % 2 == 0) ? step_size : 0) - ((row % 2 == 0) ? step_size : 0);
         SHAPE_NARROW:
            acc = longint'($urandom_range(3, 0)) - 1;
         SHAPE_NOISE:
            acc = longint'($urandom);
         SHAPE_EXTREME:
            case ($urandom_range(4, 0))
               0:       acc = longint'(PSI_MIN);
               1:       acc = longint'(PSI_MAX);
               2:       acc = 0;
               3:       acc = -1;
               default: acc = 1;
            endcase
         default:
            if ($urandom_range(7, 0) == 0) acc = offset + longint'($urandom_range(2, 0)) - 1;
      endcase
      return acc[31:0];
   endfunction

   function automatic frame_shape_type pick_shape();
      int roll;
      roll = $urandom_range(19, 0);
      if (roll < 10) return SHAPE_QUADRATIC;
      if (roll < 12) return SHAPE_TILED;
      if (roll < 15) return SHAPE_NARROW;
      if (roll < 17) return SHAPE_NOISE;
      if (roll < 18) return SHAPE_EXTREME;
      return SHAPE_PLATEAU;
   endfunction

   task automatic send_frame(input frame_shape_type shape);
      center_col = longint'($urandom_range(columns_now - 1, 0));
      center_row = longint'($urandom_range(rows_now - 1, 0));
      bend_col = longint'($urandom_range(16384, 1));
      if ($urandom_range(1, 0) == 1) bend_col = -bend_col;
      bend_row = longint'($urandom_range(16384, 1));
      if ($urandom_range(1, 0) == 1) bend_row = -bend_row;
      twist = ($urandom_range(3, 0) == 0) ? longint'($urandom_range(32768, 0)) - 16384 : 0;
      offset = longint'(int'($urandom)) / 2;
      step_size = longint'($urandom_range(32'h2000_0000, 1));
      offset = (shape == SHAPE_TILED) ? offset / 2 : offset;
      case ($urandom_range(2, 0))
         0:       jitter = 0;
         1:       jitter = 3;
         default: jitter = 255;
      endcase
      for (int r = 0; r < rows_now; r++) begin
         for (int c = 0; c < columns_now; c++) begin
            push_sample(grid_value(shape, c, r));
         end
      end
   endtask

   // Result side: hold ready low for a drawn number of cycles before each result.
   initial begin
      int rsp_gap;
      rsp_if.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         rsp_gap = next_gap(rsp_calm);
         if (rsp_gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (rsp_gap) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         @(negedge clock);
      end
   end

   initial begin
      #25ms;
      $display("testbench: done, errors");
      $finish;
   end

   initial begin
      int                       phase;
      int                       frame_count;
      int                       roll;
      bit                       big;
      logic [CSR_DATA_BITS-1:0] cols_raw;
      logic [CSR_DATA_BITS-1:0] rows_raw;
      logic signed [31:0]       directed[18];

      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.psi_sample = '0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_GRID_COLUMNS;
      csr_if.data = '0;
      req_calm = 1'b0;
      rsp_calm = 1'b0;
      columns_now = 256;
      rows_now = 256;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_register(CSR_GRID_COLUMNS, 13'd3);
      write_register(CSR_GRID_ROWS, 13'd3);
      // Saddle from the curvature with extreme neighbors, then one from the
      // mixed term alone with flat rows and columns.
      directed = '{0, PSI_MIN, 0, PSI_MAX, 0, PSI_MAX, 0, PSI_MIN, 0,
                   PSI_MIN, 5, PSI_MAX, 5, 5, 5, PSI_MAX, 5, PSI_MIN};
      foreach (directed[i]) push_sample(directed[i]);
      finish_outstanding();

      random_items = 0;
      for (phase = 0; random_items < RANDOM_ITEMS; phase++) begin
         big = (phase == 2 || phase == 5);
         req_calm = ($urandom_range(3, 0) == 0);
         rsp_calm = ($urandom_range(3, 0) == 0);
         case (phase)
            // Oversized column count fills the whole line buffer
            2: begin
               cols_raw = 13'h1FFF;
               rows_raw = 13'd3;
            end
            5: begin
               cols_raw = CSR_DATA_BITS'($urandom_range(2, 0));
               rows_raw = CSR_DATA_BITS'($urandom_range(2, 0));
            end
            default: begin
               roll = $urandom_range(9, 0);
               cols_raw = CSR_DATA_BITS'((roll == 0) ? $urandom_range(2, 0) :
                          (roll == 1) ? $urandom_range(24, 11) : $urandom_range(8, 3));
               roll = $urandom_range(9, 0);
               rows_raw = CSR_DATA_BITS'((roll == 0) ? $urandom_range(2, 0) :
                          (roll == 1) ? $urandom_range(10, 7) : $urandom_range(6, 3));
            end
         endcase
         if (big || $urandom_range(4, 0) != 0) write_register(CSR_GRID_COLUMNS, cols_raw);
         if (big || $urandom_range(4, 0) != 0) write_register(CSR_GRID_ROWS, rows_raw);
         if ($urandom_range(5, 0) == 0) begin
            write_register(CSR_SPARE_LOW, CSR_DATA_BITS'($urandom_range(8191, 0)));
            write_register(CSR_SPARE_HIGH, CSR_DATA_BITS'($urandom_range(8191, 0)));
         end
         frame_count = big ? 1 : $urandom_range(4, 1);
         repeat (frame_count) begin
            send_frame(big ? SHAPE_QUADRATIC : pick_shape());
            random_items += columns_now * rows_now;
         end
         finish_outstanding();
      end

      if (mismatches == 0 && outstanding == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

### grid_saddle_point_finder_unit.f
+incdir+rtl
rtl/gspf_pkg.sv
rtl/gspf_ifs.sv
rtl/gspf_hessian_mult.sv
rtl/grid_saddle_point_finder_unit.sv
tb/sv/saddle_checker.sv
tb/sv/testbench.sv
